// File: src/sare_pkg.sv
// Shared types, register map and constants of the sensor alert rule engine.
package sare_pkg;

	localparam int SoilW = 10;
	localparam int TempW = 12;
	localparam int HumW = 10;
	localparam int TimeW = 32;
	localparam int CountW = 8;
	localparam int BLIGHT_RUN_LENGTH_DEF = 6;

	localparam int InDataW = 64;
	localparam int OutDataW = 32;
	localparam int ApbAddrW = 5;
	localparam int ApbDataW = 32;

	localparam logic [2:0] REG_SOIL_LOW = 3'd0;
	localparam logic [2:0] REG_SOIL_HIGH = 3'd1;
	localparam logic [2:0] REG_HEAT_LIMIT = 3'd2;
	localparam logic [2:0] REG_BLIGHT_TFLOOR = 3'd3;
	localparam logic [2:0] REG_BLIGHT_TCEIL = 3'd4;
	localparam logic [2:0] REG_BLIGHT_HFLOOR = 3'd5;
	localparam logic [2:0] REG_COOLDOWN = 3'd6;

	localparam logic [SoilW-1:0] SOIL_LOW_RST = 10'd300;
	localparam logic [SoilW-1:0] SOIL_HIGH_RST = 10'd800;
	localparam logic signed [TempW-1:0] HEAT_LIMIT_RST = 12'sd350;
	localparam logic signed [TempW-1:0] BLIGHT_TFLOOR_RST = 12'sd100;
	localparam logic signed [TempW-1:0] BLIGHT_TCEIL_RST = 12'sd250;
	localparam logic [HumW-1:0] BLIGHT_HFLOOR_RST = 10'd900;
	localparam logic [TimeW-1:0] COOLDOWN_RST = 32'd3600;

	typedef enum logic [2:0] {
		KIND_NONE = 3'd0,
		KIND_FLOOD = 3'd1,
		KIND_DROUGHT = 3'd2,
		KIND_HEAT = 3'd3,
		KIND_BLIGHT = 3'd4
	} alert_kind_t;

	typedef enum logic [1:0] {
		SEV_NOTE = 2'd0,
		SEV_WARN = 2'd1,
		SEV_CRIT = 2'd2
	} alert_sev_t;

	typedef struct packed {
		logic [SoilW-1:0] soil_low_limit;
		logic [SoilW-1:0] soil_high_limit;
		logic signed [TempW-1:0] heat_limit;
		logic signed [TempW-1:0] blight_temp_floor;
		logic signed [TempW-1:0] blight_temp_ceiling;
		logic [HumW-1:0] blight_humidity_floor;
		logic [TimeW-1:0] cooldown_seconds;
	} cfg_t;

	typedef struct packed {
		logic [TimeW-1:0] now_seconds;
		logic [HumW-1:0] air_humidity;
		logic signed [TempW-1:0] air_temperature;
		logic [SoilW-1:0] soil_moisture;
	} reading_t;

	typedef struct packed {
		logic signed [TempW-1:0] threshold_value;
		logic signed [TempW-1:0] trigger_value;
		alert_sev_t alert_severity;
		alert_kind_t alert_kind;
	} result_t;

endpackage

// File: src/sare_cfg_regs.sv
// APB register file holding the alert thresholds and the cooldown.
module sare_cfg_regs import sare_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ApbAddrW-1:0] paddr,
	input  logic [ApbDataW-1:0] pwdata,
	output logic [ApbDataW-1:0] prdata,
	output logic                pready,
	output cfg_t                cfg
);

	cfg_t cfg_q;
	logic wr_en;
	logic [2:0] reg_idx;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite;
	assign reg_idx = paddr[4:2];
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.soil_low_limit <= SOIL_LOW_RST;
			cfg_q.soil_high_limit <= SOIL_HIGH_RST;
			cfg_q.heat_limit <= HEAT_LIMIT_RST;
			cfg_q.blight_temp_floor <= BLIGHT_TFLOOR_RST;
			cfg_q.blight_temp_ceiling <= BLIGHT_TCEIL_RST;
			cfg_q.blight_humidity_floor <= BLIGHT_HFLOOR_RST;
			cfg_q.cooldown_seconds <= COOLDOWN_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_SOIL_LOW: cfg_q.soil_low_limit <= pwdata[SoilW-1:0];
				REG_SOIL_HIGH: cfg_q.soil_high_limit <= pwdata[SoilW-1:0];
				REG_HEAT_LIMIT: cfg_q.heat_limit <= pwdata[TempW-1:0];
				REG_BLIGHT_TFLOOR: cfg_q.blight_temp_floor <= pwdata[TempW-1:0];
				REG_BLIGHT_TCEIL: cfg_q.blight_temp_ceiling <= pwdata[TempW-1:0];
				REG_BLIGHT_HFLOOR: cfg_q.blight_humidity_floor <= pwdata[HumW-1:0];
				REG_COOLDOWN: cfg_q.cooldown_seconds <= pwdata[TimeW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SOIL_LOW: prdata = {{(ApbDataW-SoilW){1'b0}}, cfg_q.soil_low_limit};
			REG_SOIL_HIGH: prdata = {{(ApbDataW-SoilW){1'b0}}, cfg_q.soil_high_limit};
			REG_HEAT_LIMIT: prdata = {{(ApbDataW-TempW){1'b0}}, cfg_q.heat_limit};
			REG_BLIGHT_TFLOOR: prdata = {{(ApbDataW-TempW){1'b0}}, cfg_q.blight_temp_floor};
			REG_BLIGHT_TCEIL: prdata = {{(ApbDataW-TempW){1'b0}}, cfg_q.blight_temp_ceiling};
			REG_BLIGHT_HFLOOR:
				prdata = {{(ApbDataW-HumW){1'b0}}, cfg_q.blight_humidity_floor};
			REG_COOLDOWN: prdata = cfg_q.cooldown_seconds;
			default: prdata = '0;
		endcase
	end

endmodule

// File: src/sare_rules.sv
// Rule evaluation with the per-alert last-fire times and the blight run counter.
module sare_rules import sare_pkg::*; #(
	parameter int BLIGHT_RUN_LENGTH = BLIGHT_RUN_LENGTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     advance,
	input  reading_t rd,
	input  cfg_t     cfg,
	output result_t  res
);

	logic [TimeW-1:0] last_flood_q, last_drought_q, last_heat_q, last_blight_q;
	logic [CountW-1:0] run_count_q;
	logic [CountW-1:0] count_inc;
	logic flood_hit, drought_hit, heat_hit, blight_hit, window;

	// Time running backwards counts as an elapsed cooldown.
	function automatic logic cool_done(input logic [TimeW-1:0] last,
			input logic [TimeW-1:0] now, input logic [TimeW-1:0] cd);
		logic [TimeW-1:0] diff;
		diff = now - last;
		return (now < last) || (diff >= cd);
	endfunction

	always_comb begin
		flood_hit = (rd.soil_moisture > cfg.soil_high_limit) &&
			cool_done(last_flood_q, rd.now_seconds, cfg.cooldown_seconds);
		drought_hit = (rd.soil_moisture < cfg.soil_low_limit) &&
			cool_done(last_drought_q, rd.now_seconds, cfg.cooldown_seconds);
		heat_hit = (rd.air_temperature > cfg.heat_limit) &&
			cool_done(last_heat_q, rd.now_seconds, cfg.cooldown_seconds);
		window = (rd.air_humidity >= cfg.blight_humidity_floor) &&
			(rd.air_temperature >= cfg.blight_temp_floor) &&
			(rd.air_temperature <= cfg.blight_temp_ceiling);
		count_inc = (run_count_q == '1) ? run_count_q : run_count_q + 1'b1;
		blight_hit = window && (count_inc >= CountW'(BLIGHT_RUN_LENGTH)) &&
			cool_done(last_blight_q, rd.now_seconds, cfg.cooldown_seconds);
	end

	always_comb begin
		priority if (flood_hit) begin
			res.alert_kind = KIND_FLOOD;
			res.alert_severity = SEV_CRIT;
			res.trigger_value = {{(TempW-SoilW){1'b0}}, rd.soil_moisture};
			res.threshold_value = {{(TempW-SoilW){1'b0}}, cfg.soil_high_limit};
		end else if (drought_hit) begin
			res.alert_kind = KIND_DROUGHT;
			res.alert_severity = SEV_CRIT;
			res.trigger_value = {{(TempW-SoilW){1'b0}}, rd.soil_moisture};
			res.threshold_value = {{(TempW-SoilW){1'b0}}, cfg.soil_low_limit};
		end else if (heat_hit) begin
			res.alert_kind = KIND_HEAT;
			res.alert_severity = SEV_WARN;
			res.trigger_value = rd.air_temperature;
			res.threshold_value = cfg.heat_limit;
		end else if (blight_hit) begin
			res.alert_kind = KIND_BLIGHT;
			res.alert_severity = SEV_CRIT;
			res.trigger_value = {{(TempW-HumW){1'b0}}, rd.air_humidity};
			res.threshold_value = {{(TempW-HumW){1'b0}}, cfg.blight_humidity_floor};
		end else begin
			res.alert_kind = KIND_NONE;
			res.alert_severity = SEV_NOTE;
			res.trigger_value = '0;
			res.threshold_value = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_flood_q <= '0;
			last_drought_q <= '0;
			last_heat_q <= '0;
			last_blight_q <= '0;
			run_count_q <= '0;
		end else if (advance) begin
			priority if (flood_hit) begin
				last_flood_q <= rd.now_seconds;
			end else if (drought_hit) begin
				last_drought_q <= rd.now_seconds;
			end else if (heat_hit) begin
				last_heat_q <= rd.now_seconds;
			end else if (blight_hit) begin
				last_blight_q <= rd.now_seconds;
				run_count_q <= '0;
			end else if (window) begin
				run_count_q <= count_inc;
			end else begin
				run_count_q <= '0;
			end
		end
	end

endmodule

// File: src/sensor_alert_rule_engine.sv
// Top level of the sensor alert rule engine: stream ports, input and result registers.
// Each reading beat gives exactly one result beat. A reading is captured in an input register,
// the rules are evaluated against the per-alert state while it is held there, and the result is
// written to an output register once that register is free. One reading can be accepted every
// cycle while the output is not stalled; the rule state is updated in the same cycle as its
// reading is evaluated, which sets the throughput at one beat per clock when the output keeps
// up. A stalled output holds its result while the input register keeps one more reading waiting.
module sensor_alert_rule_engine import sare_pkg::*; #(
	parameter int BLIGHT_RUN_LENGTH = BLIGHT_RUN_LENGTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// soil_moisture[9:0], air_temperature[21:10], air_humidity[31:22], now_seconds[63:32]
	input  logic [InDataW-1:0]  s_axis_tdata,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// alert_kind[2:0], alert_severity[4:3], trigger_value[16:5], threshold_value[28:17], zeros
	output logic [OutDataW-1:0] m_axis_tdata,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ApbAddrW-1:0] paddr,
	input  logic [ApbDataW-1:0] pwdata,
	output logic [ApbDataW-1:0] prdata,
	output logic                pready
);

	cfg_t cfg;
	reading_t rd_s1;
	logic valid_s1;
	result_t res_comb;
	result_t res_q;
	logic res_valid_q;
	logic res_free;
	logic advance;

	sare_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	assign res_free = !res_valid_q || m_axis_tready;
	assign advance = valid_s1 && res_free;
	assign s_axis_tready = !valid_s1 || res_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			rd_s1 <= s_axis_tdata;
		end
	end

	sare_rules #(
		.BLIGHT_RUN_LENGTH(BLIGHT_RUN_LENGTH)
	) u_rules (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.rd     (rd_s1),
		.cfg    (cfg),
		.res    (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_free) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_comb;
		end
	end

	assign m_axis_tvalid = res_valid_q;
	assign m_axis_tdata = {{(OutDataW-$bits(result_t)){1'b0}}, res_q};

endmodule
